[sv/mm_pkg.sv]
// shared types, constants and helpers of the matrix multiply block
`default_nettype none

package mm_pkg;

    // default sizing handed to the top level parameters
    localparam int unsigned MAX_DIM_DEF    = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned PRODUCT_W = 32;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned DIM_W     = 5;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned OP_MAX_W  = 32;

    // apb port sizing
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // register reset values
    localparam logic [DIM_W-1:0] ROWS_A_RST = DIM_W'(16);
    localparam logic [DIM_W-1:0] COLS_A_RST = DIM_W'(16);
    localparam logic [DIM_W-1:0] COLS_B_RST = DIM_W'(16);
    localparam logic             B_TRANS_RST = 1'b0;

    // transaction mode codes, code 3 is ignored
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_CALC   = 2'd2
    } t_mode;

    // register index within the apb window
    typedef enum logic [1:0] {
        REG_ROWS_A  = 2'd0,
        REG_COLS_A  = 2'd1,
        REG_COLS_B  = 2'd2,
        REG_B_TRANS = 2'd3
    } t_reg_idx;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] cols_b;
        logic             b_transposed;
    } t_cfg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic step;
        logic acc_clr;
        logic finalize;
        logic last;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_status;

    // a zero dimension acts as one, a large one is clamped to max_dim
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/mm_in_if.sv]
// input channel of the matrix multiply block
`default_nettype none

interface mm_in_if;
    logic                                valid;
    logic                                ready;
    logic [mm_pkg::MODE_W-1:0]           mode;
    logic signed [mm_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

[sv/mm_out_if.sv]
// result channel of the matrix multiply block
`default_nettype none

interface mm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mm_pkg::PRODUCT_W-1:0] product;
    logic                                last;

    modport source (output valid, output product, output last, input ready);
    modport sink   (input valid, input product, input last, output ready);
endinterface

`default_nettype wire

[sv/mm_regs.sv]
// apb configuration registers of the matrix multiply block
`default_nettype none

module mm_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mm_pkg::APB_DW-1:0]   pwdata,
    output logic      [mm_pkg::APB_DW-1:0]   prdata,
    output logic                             pready,
    output mm_pkg::t_cfg                     o_cfg,
    output logic                             o_cfg_wr
);

    mm_pkg::t_cfg      r_cfg;
    logic              w_wr;
    logic [1:0]        w_idx;

    // access phase of a write transaction
    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[mm_pkg::APB_AW-1:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_a       <= mm_pkg::ROWS_A_RST;
            r_cfg.cols_a       <= mm_pkg::COLS_A_RST;
            r_cfg.cols_b       <= mm_pkg::COLS_B_RST;
            r_cfg.b_transposed <= mm_pkg::B_TRANS_RST;
        end else if (w_wr) begin
            case (w_idx)
                mm_pkg::REG_ROWS_A:  r_cfg.rows_a       <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_COLS_A:  r_cfg.cols_a       <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_COLS_B:  r_cfg.cols_b       <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_B_TRANS: r_cfg.b_transposed <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            mm_pkg::REG_ROWS_A:  prdata = mm_pkg::APB_DW'(r_cfg.rows_a);
            mm_pkg::REG_COLS_A:  prdata = mm_pkg::APB_DW'(r_cfg.cols_a);
            mm_pkg::REG_COLS_B:  prdata = mm_pkg::APB_DW'(r_cfg.cols_b);
            mm_pkg::REG_B_TRANS: prdata = mm_pkg::APB_DW'(r_cfg.b_transposed);
            default:             prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_cfg    = r_cfg;
    // every register write restarts loading and output order
    assign o_cfg_wr = w_wr;

endmodule

`default_nettype wire

[sv/mm_ctrl.sv]
// sequencer: load pointers, output position, dot product address walk
`default_nettype none

module mm_ctrl #(
    parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mm_pkg::t_cfg                  i_cfg,
    input  wire logic                          i_cfg_wr,
    input  wire logic                          i_valid,
    input  wire logic [mm_pkg::MODE_W-1:0]     i_mode,
    output logic                               o_ready,
    input  wire mm_pkg::t_dp_status            i_status,
    output mm_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_rd_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_rd_addr_b
);

    localparam int unsigned ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int unsigned LIM_W  = ADDR_W + 1;
    localparam int unsigned DIM_W  = mm_pkg::DIM_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_a_ptr, n_a_ptr;
    logic [ADDR_W-1:0]    r_b_ptr, n_b_ptr;
    logic [DIM_W-1:0]     r_row, n_row;
    logic [DIM_W-1:0]     r_col, n_col;
    logic [ADDR_W-1:0]    r_a_base, n_a_base;
    logic [ADDR_W-1:0]    r_bt_base, n_bt_base;
    logic [DIM_W-1:0]     r_k, n_k;
    logic [ADDR_W-1:0]    r_a_addr, n_a_addr;
    logic [ADDR_W-1:0]    r_b_addr, n_b_addr;

    logic [DIM_W-1:0]     w_nr, w_nk, w_nc;
    logic [2*DIM_W-1:0]   w_prod_a, w_prod_b;
    logic [LIM_W-1:0]     w_lim_a, w_lim_b;
    logic [LIM_W-1:0]     w_a_ptr_inc, w_b_ptr_inc;
    logic                 w_accept;
    logic                 w_last;
    logic                 w_col_end;
    logic                 w_row_end;

    // effective dimensions and matrix sizes
    assign w_nr     = mm_pkg::eff_dim(i_cfg.rows_a, MAX_DIM);
    assign w_nk     = mm_pkg::eff_dim(i_cfg.cols_a, MAX_DIM);
    assign w_nc     = mm_pkg::eff_dim(i_cfg.cols_b, MAX_DIM);
    assign w_prod_a = w_nr * w_nk;
    assign w_prod_b = w_nk * w_nc;
    assign w_lim_a  = LIM_W'(w_prod_a);
    assign w_lim_b  = LIM_W'(w_prod_b);

    assign w_a_ptr_inc = LIM_W'(r_a_ptr) + LIM_W'(1);
    assign w_b_ptr_inc = LIM_W'(r_b_ptr) + LIM_W'(1);

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid & o_ready;
    assign w_col_end = (r_col == w_nc - DIM_W'(1));
    assign w_row_end = (r_row == w_nr - DIM_W'(1));
    assign w_last    = w_col_end & w_row_end;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_a_ptr   = r_a_ptr;
        n_b_ptr   = r_b_ptr;
        n_row     = r_row;
        n_col     = r_col;
        n_a_base  = r_a_base;
        n_bt_base = r_bt_base;
        n_k       = r_k;
        n_a_addr  = r_a_addr;
        n_b_addr  = r_b_addr;
        o_cmd     = '0;
        o_wr_addr = r_a_ptr;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        mm_pkg::MODE_LOAD_A: begin
                            o_cmd.wr_a = 1'b1;
                            o_wr_addr  = r_a_ptr;
                            n_a_ptr    = (w_a_ptr_inc >= w_lim_a) ? '0
                                                                  : ADDR_W'(w_a_ptr_inc);
                        end
                        mm_pkg::MODE_LOAD_B: begin
                            o_cmd.wr_b = 1'b1;
                            o_wr_addr  = r_b_ptr;
                            n_b_ptr    = (w_b_ptr_inc >= w_lim_b) ? '0
                                                                  : ADDR_W'(w_b_ptr_inc);
                        end
                        mm_pkg::MODE_CALC: begin
                            // start a dot product at the current output position
                            o_cmd.acc_clr = 1'b1;
                            n_a_addr      = r_a_base;
                            n_b_addr      = i_cfg.b_transposed ? r_bt_base
                                                               : ADDR_W'(r_col);
                            n_k           = '0;
                            n_state       = S_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                // one multiply-accumulate read per cycle
                o_cmd.step = 1'b1;
                n_a_addr   = r_a_addr + ADDR_W'(1);
                n_b_addr   = r_b_addr + (i_cfg.b_transposed ? ADDR_W'(1) : ADDR_W'(w_nc));
                n_k        = r_k + DIM_W'(1);
                if (r_k == w_nk - DIM_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the mac pipe to empty and the output slot to open
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.finalize = 1'b1;
                    o_cmd.last     = w_last;
                    n_state        = S_IDLE;
                    if (w_col_end) begin
                        n_col     = '0;
                        n_bt_base = '0;
                        if (w_row_end) begin
                            n_row    = '0;
                            n_a_base = '0;
                        end else begin
                            n_row    = r_row + DIM_W'(1);
                            n_a_base = r_a_base + ADDR_W'(w_nk);
                        end
                    end else begin
                        n_col     = r_col + DIM_W'(1);
                        n_bt_base = r_bt_base + ADDR_W'(w_nk);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a register write restarts loading and output order
        if (i_cfg_wr) begin
            n_a_ptr   = '0;
            n_b_ptr   = '0;
            n_row     = '0;
            n_col     = '0;
            n_a_base  = '0;
            n_bt_base = '0;
        end
    end

    assign o_rd_addr_a = r_a_addr;
    assign o_rd_addr_b = r_b_addr;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a_ptr   <= '0;
            r_b_ptr   <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_a_base  <= '0;
            r_bt_base <= '0;
            r_k       <= '0;
            r_a_addr  <= '0;
            r_b_addr  <= '0;
        end else begin
            r_state   <= n_state;
            r_a_ptr   <= n_a_ptr;
            r_b_ptr   <= n_b_ptr;
            r_row     <= n_row;
            r_col     <= n_col;
            r_a_base  <= n_a_base;
            r_bt_base <= n_bt_base;
            r_k       <= n_k;
            r_a_addr  <= n_a_addr;
            r_b_addr  <= n_b_addr;
        end
    end

endmodule

`default_nettype wire

[sv/mm_dp.sv]
// datapath: operand stores, multiply-accumulate, saturation, output register
`default_nettype none

module mm_dp #(
    parameter int unsigned MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int unsigned DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mm_pkg::t_dp_cmd                     i_cmd,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  i_wr_addr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  i_rd_addr_a,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  i_rd_addr_b,
    input  wire logic signed [mm_pkg::VALUE_W-1:0]   i_value,
    output mm_pkg::t_dp_status                       o_status,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic signed [mm_pkg::PRODUCT_W-1:0]      o_product,
    output logic                                     o_last
);

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned OP_W   = (DATA_WIDTH < mm_pkg::OP_MAX_W) ? DATA_WIDTH
                                                                     : mm_pkg::OP_MAX_W;
    localparam int unsigned MUL_W  = 2 * OP_W;
    localparam int unsigned ACC_W  = MUL_W + mm_pkg::DIM_W;
    localparam int unsigned Q_W    = ACC_W - mm_pkg::FRAC_W;

    localparam logic signed [Q_W-1:0] Q_HI = {{(Q_W-OP_W+1){1'b0}}, {(OP_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO = ~Q_HI;

    logic signed [OP_W-1:0]   r_store_a [DEPTH];
    logic signed [OP_W-1:0]   r_store_b [DEPTH];
    logic signed [OP_W-1:0]   r_rd_a;
    logic signed [OP_W-1:0]   r_rd_b;
    logic                     r_rd_vld;
    logic signed [MUL_W-1:0]  r_mul;
    logic                     r_mul_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [mm_pkg::PRODUCT_W-1:0] r_product;
    logic                     r_last;

    logic signed [OP_W-1:0]   w_operand;
    logic signed [Q_W-1:0]    w_q;
    logic signed [OP_W-1:0]   w_sat;

    // operand is the low bits of the value, two's complement
    assign w_operand = OP_W'(i_value);

    // store a: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_store_a[i_wr_addr] <= w_operand;
        end
        r_rd_a <= r_store_a[i_rd_addr_a];
    end

    // store b: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_store_b[i_wr_addr] <= w_operand;
        end
        r_rd_b <= r_store_b[i_rd_addr_b];
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_mul <= r_rd_a * r_rd_b;
    end

    // accumulate stage, exact sum of the products
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + ACC_W'(r_mul);
        end
    end

    // valid bits of the mac pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.step;
            r_mul_vld <= r_rd_vld;
        end
    end

    // drop fraction bits toward minus infinity, then saturate
    assign w_q = r_acc[ACC_W-1:mm_pkg::FRAC_W];

    always_comb begin
        if (w_q > Q_HI) begin
            w_sat = OP_W'(Q_HI);
        end else if (w_q < Q_LO) begin
            w_sat = OP_W'(Q_LO);
        end else begin
            w_sat = OP_W'(w_q);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finalize) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finalize) begin
            r_product <= mm_pkg::PRODUCT_W'(w_sat);
            r_last    <= i_cmd.last;
        end
    end

    assign o_status.busy     = r_rd_vld | r_mul_vld;
    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_product         = r_product;
    assign o_last            = r_last;

endmodule

`default_nettype wire

[sv/matrix_multiply.sv]
// top level of the matrix multiply block
`default_nettype none

// Fixed-point matrix multiply C = A * B with signed Q16.16 operands. Mode 0
// transactions load A row by row, mode 1 transactions load B in its stored
// order (transposed when b_transposed is set), and each mode 2 transaction
// returns the next element of C in row-major order, with last set on the
// final one. A mode 2 transaction occupies the block until its result
// enters the output register, and longer while the previous result still
// waits to be taken: one multiply-accumulate unit, a multiply stage then
// an accumulate stage, walks the dot product, one term a cycle, after a
// registered read of both operand memories, and the sum is rounded toward
// minus infinity and saturated on its way into the output register. The
// next transaction is taken while a result waits in that register.
// Register writes restart loading and output order and keep the stored
// elements; write them only while the block is idle.

module matrix_multiply #(
    parameter int unsigned MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int unsigned DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mm_in_if.sink                            i_in,
    mm_out_if.source                         o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mm_pkg::APB_DW-1:0]   pwdata,
    output logic      [mm_pkg::APB_DW-1:0]   prdata,
    output logic                             pready
);

    localparam int unsigned ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    mm_pkg::t_cfg        w_cfg;
    logic                w_cfg_wr;
    mm_pkg::t_dp_cmd     w_cmd;
    mm_pkg::t_dp_status  w_status;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ADDR_W-1:0]   w_rd_addr_a;
    logic [ADDR_W-1:0]   w_rd_addr_b;
    logic                w_ready;

    // configuration registers
    mm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_cfg_wr (w_cfg_wr)
    );

    // controller
    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cfg_wr    (w_cfg_wr),
        .i_valid     (i_in.valid),
        .i_mode      (i_in.mode),
        .o_ready     (w_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b)
    );

    // datapath
    mm_dp #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_wr_addr   (w_wr_addr),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .i_value     (i_in.value),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_product   (o_out.product),
        .o_last      (o_out.last)
    );

    assign i_in.ready = w_ready;

    // result is only taken from a drained mac pipe
    a_finalize_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finalize |-> !w_status.busy)
        else $error("finalize while mac pipe busy");

    // a pending result is never overwritten
    a_finalize_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finalize |-> (!o_out.valid || o_out.ready))
        else $error("output register overwritten");

    // a product transaction blocks the input on the next cycle
    a_calc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == mm_pkg::MODE_CALC) |=> !i_in.ready)
        else $error("input open during dot product");

    // loads and mac reads never overlap
    a_no_load_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !(w_cmd.wr_a || w_cmd.wr_b))
        else $error("store write during dot product");

endmodule

`default_nettype wire
